// ===== rtl/mce_pkg.sv =====
// Package for the motion command encoder: types, codes, reset values and helpers.
`timescale 1ns / 1ps
`default_nettype none

package mce_pkg;

  localparam int unsigned WheelW = 41;
  localparam int unsigned MagW   = 40;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned ProdW  = 56;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_WHEEL_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TURN_GAIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WHEEL_DIVISOR = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TURN_LIMIT    = 3'd4;

  localparam logic        RST_WHEEL_MODE    = 1'b0;
  localparam logic [23:0] RST_TURN_GAIN     = 24'd65536;
  localparam logic [7:0]  RST_WHEEL_DIVISOR = 8'd20;
  localparam logic [14:0] RST_SPEED_LIMIT   = 15'd500;
  localparam logic [14:0] RST_TURN_LIMIT    = 15'd100;
  localparam logic [1:0]  RST_STEPS         = 2'd2;

  localparam logic [1:0] KIND_WHEELS = 2'd0;
  localparam logic [1:0] KIND_TRANS  = 2'd1;
  localparam logic [1:0] KIND_ROT    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_MIX,
    ST_CHK_L,
    ST_DIV_L,
    ST_SCL_L,
    ST_APL_L,
    ST_CHK_R,
    ST_DIV_R,
    ST_SCL_R,
    ST_APL_R,
    ST_BYT_R,
    ST_BYT_L,
    ST_FIN
  } mce_state_e;

  typedef struct packed {
    logic [7:0] val;
    logic       sat;
  } byte_res_t;

  function automatic logic [WheelW-1:0] with_sign(input logic neg, input logic [MagW-1:0] m);
    logic [WheelW-1:0] e;
    e = {1'b0, m};
    return neg ? (~e + WheelW'(1)) : e;
  endfunction

  function automatic logic [MagW-1:0] wheel_mag(input logic [WheelW-1:0] w);
    logic [WheelW-1:0] n;
    n = ~w + WheelW'(1);
    return w[WheelW-1] ? n[MagW-1:0] : w[MagW-1:0];
  endfunction

  function automatic byte_res_t sat_byte(input logic neg, input logic [QuoW-1:0] q);
    byte_res_t r;
    logic [QuoW-1:0] m;
    if (neg) begin
      r.sat = (q > 16'd128);
      m = r.sat ? 16'd128 : q;
      r.val = (~m[7:0]) + 8'd1;
    end else begin
      r.sat = (q > 16'd127);
      m = r.sat ? 16'd127 : q;
      r.val = m[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/motion_command_encoder_top.sv =====
// Motion command encoder: speed and turn-rate demand to one motor command.
// Separate mode: result registered as the item is taken; one item per cycle at most.
// Wheel mode: a state machine mixes the wheels, clamps and rescales them, then makes a byte of each;
//   it runs the shared radix-2 divider twice, and once more for each wheel that clamps (two to four).
// One item at a time; a new item waits until the output register is free.
// Reset: registers to their defaults, last demands zero, rotation counter at two.
`timescale 1ns / 1ps
`default_nettype none

module motion_command_encoder_top
  import mce_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // speed_demand[15:0], turn_rate_demand[31:16]
  input  wire logic [31:0]         s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // right_wheel[7:0], left_wheel[15:8], forward[16], magnitude[32:17], limited[33]
  output logic [39:0]              m_axis_tdata,
  // command_kind[1:0]
  output logic [1:0]               m_axis_tuser
);

  mce_state_e state_q, state_d;

  logic        wheel_mode_q;
  logic [23:0] turn_gain_q;
  logic [7:0]  wheel_div_q;
  logic [14:0] speed_limit_q;
  logic [14:0] turn_limit_q;

  logic [15:0] last_speed_q, last_speed_d;
  logic [15:0] last_turn_q, last_turn_d;
  logic [1:0]  steps_q, steps_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;

  logic [15:0]       speed_q, speed_d;
  logic [15:0]       turn_q, turn_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [WheelW-1:0] lw_q, lw_d;
  logic [WheelW-1:0] rw_q, rw_d;
  logic [MagW-1:0]   rem_q, rem_d;
  logic [MagW-1:0]   den_q, den_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic              limited_q, limited_d;
  logic [7:0]        right_q, right_d;

  logic [1:0]  out_kind_q, out_kind_d;
  logic [7:0]  out_right_q, out_right_d;
  logic [7:0]  out_left_q, out_left_d;
  logic        out_fwd_q, out_fwd_d;
  logic [15:0] out_mag_q, out_mag_d;
  logic        out_lim_q, out_lim_d;

  logic              in_acc;
  logic              out_free;
  logic [15:0]       speed_in, turn_in;
  logic [MagW-1:0]   mag_lw, mag_rw, lim_v;
  logic [7:0]        div_eff;
  logic [MagW-1:0]   mul_a;
  logic [23:0]       mul_b;
  logic [63:0]       mul_full;
  logic [MagW:0]     div_t;
  logic              div_ge;
  logic [MagW:0]     div_sub;
  logic [MagW-1:0]   rem_nx;
  logic [QuoW-1:0]   quo_nx;
  logic              clamp_l, clamp_r;
  logic              sel_trans;
  logic [15:0]       sel_d, sel_mag, sel_lim;
  logic [15:0]       turn_abs;
  logic [WheelW-1:0] rot_s, speed_ext;
  byte_res_t         byte_res;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign speed_in      = s_axis_tdata[15:0];
  assign turn_in       = s_axis_tdata[31:16];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {6'b0, out_lim_q, out_mag_q, out_fwd_q, out_left_q, out_right_q};

  assign mag_lw  = wheel_mag(lw_q);
  assign mag_rw  = wheel_mag(rw_q);
  assign lim_v   = {9'b0, speed_limit_q, 16'b0};
  assign div_eff = (wheel_div_q == 8'd0) ? 8'd1 : wheel_div_q;
  assign clamp_l = (mag_lw > lim_v);
  assign clamp_r = (mag_rw > lim_v);

  assign mul_full = {24'b0, mul_a} * {40'b0, mul_b};

  assign div_t   = {rem_q, quo_q[QuoW-1]};
  assign div_ge  = (div_t >= {1'b0, den_q});
  assign div_sub = div_t - {1'b0, den_q};
  assign rem_nx  = div_ge ? div_sub[MagW-1:0] : div_t[MagW-1:0];
  assign quo_nx  = {quo_q[QuoW-2:0], div_ge};

  assign turn_abs  = turn_q[15] ? (~turn_q + 16'd1) : turn_q;
  assign rot_s     = with_sign(turn_q[15], prod_q[MagW-1:0]);
  assign speed_ext = {{9{speed_q[15]}}, speed_q, 16'b0};

  assign sel_trans = ((speed_in != last_speed_q) || (turn_in == last_turn_q))
                     && (steps_q < 2'd2);
  assign sel_d     = sel_trans ? speed_in : turn_in;
  assign sel_lim   = {1'b0, sel_trans ? speed_limit_q : turn_limit_q};
  assign sel_mag   = sel_d[15] ? (~sel_d + 16'd1) : sel_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && !wheel_mode_q) state_d = ST_ROT;
      ST_ROT:   state_d = ST_MIX;
      ST_MIX:   state_d = ST_CHK_L;
      ST_CHK_L: state_d = clamp_l ? ST_DIV_L : ST_CHK_R;
      ST_DIV_L: if (cnt_q == 4'd15) state_d = ST_SCL_L;
      ST_SCL_L: state_d = ST_APL_L;
      ST_APL_L: state_d = ST_CHK_R;
      ST_CHK_R: state_d = clamp_r ? ST_DIV_R : ST_BYT_R;
      ST_DIV_R: if (cnt_q == 4'd15) state_d = ST_SCL_R;
      ST_SCL_R: state_d = ST_APL_R;
      ST_APL_R: state_d = ST_BYT_R;
      ST_BYT_R: if (cnt_q == 4'd15) state_d = ST_BYT_L;
      ST_BYT_L: if (cnt_q == 4'd15) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    last_speed_d = last_speed_q;
    last_turn_d  = last_turn_q;
    steps_d      = steps_q;
    cnt_d        = cnt_q;
    speed_d      = speed_q;
    turn_d       = turn_q;
    prod_d       = prod_q;
    lw_d         = lw_q;
    rw_d         = rw_q;
    rem_d        = rem_q;
    den_d        = den_q;
    quo_d        = quo_q;
    limited_d    = limited_q;
    right_d      = right_q;
    out_kind_d   = out_kind_q;
    out_right_d  = out_right_q;
    out_left_d   = out_left_q;
    out_fwd_d    = out_fwd_q;
    out_mag_d    = out_mag_q;
    out_lim_d    = out_lim_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    mul_a        = '0;
    mul_b        = '0;
    byte_res     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          speed_d      = speed_in;
          turn_d       = turn_in;
          last_speed_d = speed_in;
          last_turn_d  = turn_in;
          limited_d    = 1'b0;
          if (wheel_mode_q) begin
            steps_d     = sel_trans ? (steps_q + 2'd1) : 2'd0;
            out_kind_d  = sel_trans ? KIND_TRANS : KIND_ROT;
            out_right_d = 8'd0;
            out_left_d  = 8'd0;
            out_fwd_d   = !sel_d[15];
            out_mag_d   = (sel_mag > sel_lim) ? sel_lim : sel_mag;
            out_lim_d   = (sel_mag > sel_lim);
            out_valid_d = 1'b1;
          end
        end
      end
      ST_ROT: begin
        mul_a  = {24'b0, turn_abs};
        mul_b  = turn_gain_q;
        prod_d = mul_full[ProdW-1:0];
      end
      ST_MIX: begin
        lw_d = speed_ext - rot_s;
        rw_d = speed_ext + rot_s;
      end
      ST_CHK_L: begin
        if (clamp_l) begin
          limited_d = 1'b1;
          lw_d      = with_sign(lw_q[WheelW-1], lim_v);
          den_d     = mag_lw;
          rem_d     = lim_v;
          quo_d     = '0;
          cnt_d     = '0;
        end
      end
      ST_DIV_L, ST_DIV_R: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 4'd1;
      end
      ST_SCL_L: begin
        mul_a  = mag_rw;
        mul_b  = {8'b0, quo_q};
        prod_d = mul_full[ProdW-1:0];
      end
      ST_APL_L: begin
        rw_d = with_sign(rw_q[WheelW-1], prod_q[ProdW-1:16]);
      end
      ST_CHK_R: begin
        if (clamp_r) begin
          limited_d = 1'b1;
          rw_d      = with_sign(rw_q[WheelW-1], lim_v);
          den_d     = mag_rw;
          rem_d     = lim_v;
          quo_d     = '0;
        end else begin
          den_d = {32'b0, div_eff};
          rem_d = '0;
          quo_d = {1'b0, mag_rw[30:16]};
        end
        cnt_d = '0;
      end
      ST_SCL_R: begin
        mul_a  = mag_lw;
        mul_b  = {8'b0, quo_q};
        prod_d = mul_full[ProdW-1:0];
      end
      ST_APL_R: begin
        lw_d  = with_sign(lw_q[WheelW-1], prod_q[ProdW-1:16]);
        den_d = {32'b0, div_eff};
        rem_d = '0;
        quo_d = {1'b0, mag_rw[30:16]};
        cnt_d = '0;
      end
      ST_BYT_R: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          byte_res  = sat_byte(rw_q[WheelW-1], quo_nx);
          right_d   = byte_res.val;
          limited_d = limited_q | byte_res.sat;
          den_d     = {32'b0, div_eff};
          rem_d     = '0;
          quo_d     = {1'b0, mag_lw[30:16]};
          cnt_d     = '0;
        end
      end
      ST_BYT_L: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          byte_res   = sat_byte(lw_q[WheelW-1], quo_nx);
          out_left_d = byte_res.val;
          limited_d  = limited_q | byte_res.sat;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_kind_d  = KIND_WHEELS;
          out_right_d = right_q;
          out_fwd_d   = 1'b0;
          out_mag_d   = 16'd0;
          out_lim_d   = limited_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      last_speed_q  <= '0;
      last_turn_q   <= '0;
      steps_q       <= RST_STEPS;
      wheel_mode_q  <= RST_WHEEL_MODE;
      turn_gain_q   <= RST_TURN_GAIN;
      wheel_div_q   <= RST_WHEEL_DIVISOR;
      speed_limit_q <= RST_SPEED_LIMIT;
      turn_limit_q  <= RST_TURN_LIMIT;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      last_speed_q <= last_speed_d;
      last_turn_q  <= last_turn_d;
      steps_q      <= steps_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WHEEL_MODE:    wheel_mode_q  <= cfg_data_i[0];
          REG_TURN_GAIN:     turn_gain_q   <= cfg_data_i;
          REG_WHEEL_DIVISOR: wheel_div_q   <= cfg_data_i[7:0];
          REG_SPEED_LIMIT:   speed_limit_q <= cfg_data_i[14:0];
          REG_TURN_LIMIT:    turn_limit_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q     <= speed_d;
    turn_q      <= turn_d;
    prod_q      <= prod_d;
    lw_q        <= lw_d;
    rw_q        <= rw_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    quo_q       <= quo_d;
    limited_q   <= limited_d;
    right_q     <= right_d;
    out_kind_q  <= out_kind_d;
    out_right_q <= out_right_d;
    out_left_q  <= out_left_d;
    out_fwd_q   <= out_fwd_d;
    out_mag_q   <= out_mag_d;
    out_lim_q   <= out_lim_d;
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the motion command encoder: streamed demands checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import mce_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  right;
    logic [7:0]  left;
    logic        fwd;
    logic [15:0] mag;
    logic        limited;
  } motor_cmd_t;

  localparam logic [1:0] RotAgeMax   = 2'd2;
  localparam int unsigned NumSettings = 12;
  localparam int unsigned ItemsPerSetting = 130;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  // register copies and demand history
  logic        cfg_mode = RST_WHEEL_MODE;
  logic [23:0] cfg_gain = RST_TURN_GAIN;
  logic [7:0]  cfg_divisor = RST_WHEEL_DIVISOR;
  logic [14:0] cfg_speed_limit = RST_SPEED_LIMIT;
  logic [14:0] cfg_turn_limit = RST_TURN_LIMIT;
  longint      prev_speed = 0;
  longint      prev_turn = 0;
  logic [1:0]  rot_age = RST_STEPS;

  logic [31:0] demand_queue[$];
  motor_cmd_t  cmd_queue[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned n_demands = 0;
  int unsigned n_wheel = 0;
  int unsigned n_trans = 0;
  int unsigned n_rot = 0;
  int unsigned n_limited = 0;

  motion_command_encoder_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic u64_t mag64(input longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic longint signed_of(input logic neg, input u64_t m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint scale_wheel(input longint other, input longint orig, input u64_t lim_q);
    u64_t ratio;
    ratio = (lim_q << 16) / mag64(orig);
    return signed_of(other < 0, (mag64(other) * ratio) >> 16);
  endfunction

  function automatic logic [7:0] wheel_byte(input longint w, input u64_t dv, output logic sat);
    u64_t q;
    q = mag64(w) / (dv << 16);
    sat = 1'b0;
    if (w < 0 && q > 128) begin
      q = 128;
      sat = 1'b1;
    end
    if (w >= 0 && q > 127) begin
      q = 127;
      sat = 1'b1;
    end
    return (w < 0) ? 8'(~q[7:0] + 8'd1) : q[7:0];
  endfunction

  function automatic motor_cmd_t encode_demand(input logic [31:0] item);
    longint     spd, trn, lw, rw, orig, dmd;
    u64_t       lim_q, dv, cap, m;
    logic       chg_spd, chg_trn, sat;
    motor_cmd_t c;
    spd = longint'($signed(item[15:0]));
    trn = longint'($signed(item[31:16]));
    chg_spd = (spd != prev_speed);
    chg_trn = (trn != prev_turn);
    prev_speed = spd;
    prev_turn = trn;
    c = '0;
    if (!cfg_mode) begin
      lw = spd * 65536 - trn * longint'(cfg_gain);
      rw = spd * 65536 + trn * longint'(cfg_gain);
      lim_q = u64_t'(cfg_speed_limit) << 16;
      dv = (cfg_divisor == '0) ? 1 : u64_t'(cfg_divisor);
      if (mag64(lw) > lim_q) begin
        orig = lw;
        lw = signed_of(lw < 0, lim_q);
        rw = scale_wheel(rw, orig, lim_q);
        c.limited = 1'b1;
      end
      if (mag64(rw) > lim_q) begin
        orig = rw;
        rw = signed_of(rw < 0, lim_q);
        lw = scale_wheel(lw, orig, lim_q);
        c.limited = 1'b1;
      end
      c.kind = KIND_WHEELS;
      c.right = wheel_byte(rw, dv, sat);
      c.limited |= sat;
      c.left = wheel_byte(lw, dv, sat);
      c.limited |= sat;
    end else begin
      if ((chg_spd || !chg_trn) && rot_age < RotAgeMax) begin
        c.kind = KIND_TRANS;
        dmd = spd;
        cap = cfg_speed_limit;
        rot_age = rot_age + 2'd1;
      end else begin
        c.kind = KIND_ROT;
        dmd = trn;
        cap = cfg_turn_limit;
        rot_age = '0;
      end
      c.fwd = (dmd >= 0);
      m = mag64(dmd);
      if (m > cap) begin
        m = cap;
        c.limited = 1'b1;
      end
      c.mag = m[15:0];
    end
    return c;
  endfunction

  function automatic logic [31:0] demand(input int spd, input int trn);
    return {16'(trn), 16'(spd)};
  endfunction

  function automatic logic [15:0] next_value(input logic [15:0] prev);
    case ($urandom_range(9))
      0, 1, 2: return prev;
      3, 4:    return 16'($urandom());
      default: return 16'(int'($urandom_range(2400)) - 1200);
    endcase
  endfunction

  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                       input int unsigned typ);
    int unsigned v;
    case ($urandom_range(4))
      0: v = lo;
      1: v = hi;
      2: v = typ;
      3: v = $urandom_range(typ * 4, lo);
      default: v = $urandom_range(hi, lo);
    endcase
    return (v > hi) ? hi : v;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WHEEL_MODE:    cfg_mode = val[0];
      REG_TURN_GAIN:     cfg_gain = val[23:0];
      REG_WHEEL_DIVISOR: cfg_divisor = val[7:0];
      REG_SPEED_LIMIT:   cfg_speed_limit = val[14:0];
      REG_TURN_LIMIT:    cfg_turn_limit = val[14:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (demand_queue.size() != 0 || s_axis_tvalid || cmd_queue.size() != 0);
  endtask

  // driver: predict on every accepted item, then load the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_queue.push_back(encode_demand(s_axis_tdata));
        n_demands++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (demand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= demand_queue.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted command with the oldest prediction
  always @(posedge clk_i) begin : monitor
    motor_cmd_t got, want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.right = m_axis_tdata[7:0];
        got.left = m_axis_tdata[15:8];
        got.fwd = m_axis_tdata[16];
        got.mag = m_axis_tdata[32:17];
        got.limited = m_axis_tdata[33];
        case (got.kind)
          KIND_WHEELS: n_wheel++;
          KIND_TRANS:  n_trans++;
          default:     n_rot++;
        endcase
        if (got.limited) n_limited++;
        if (cmd_queue.size() == 0) begin
          errors++;
          $display("%0t: command with nothing expected, expected none, got %h", $time, got);
        end else begin
          want = cmd_queue.pop_front();
          check_field("command_kind", 16'(want.kind), 16'(got.kind));
          check_field("right_wheel", 16'(want.right), 16'(got.right));
          check_field("left_wheel", 16'(want.left), 16'(got.left));
          check_field("forward", 16'(want.fwd), 16'(got.fwd));
          check_field("magnitude", want.mag, got.mag);
          check_field("limited", 16'(want.limited), 16'(got.limited));
        end
      end
    end
  end

  initial begin
    logic [15:0] spd_v, trn_v;
    logic        mode;
    spd_v = '0;
    trn_v = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 46;

    // reset settings, wheel mode: extremes and clamps
    @(negedge clk_i);
    demand_queue.push_back(demand(0, 0));
    demand_queue.push_back(demand(32767, 0));
    demand_queue.push_back(demand(-32768, -32768));
    demand_queue.push_back(demand(32767, -32768));
    demand_queue.push_back(demand(-32768, 32767));
    demand_queue.push_back(demand(100, 10));
    demand_queue.push_back(demand(-250, -3));
    drain();

    // zero divisor, full gain, widest limit: byte saturation at both ends
    write_reg(REG_WHEEL_DIVISOR, 24'd0);
    write_reg(REG_TURN_GAIN, 24'hFFFFFF);
    write_reg(REG_SPEED_LIMIT, 24'd32767);
    @(negedge clk_i);
    demand_queue.push_back(demand(127, 0));
    demand_queue.push_back(demand(128, 0));
    demand_queue.push_back(demand(-128, 0));
    demand_queue.push_back(demand(-129, 0));
    demand_queue.push_back(demand(-32768, 0));
    demand_queue.push_back(demand(0, 1));
    drain();

    // zero speed limit, and a write to an unused index that must be dropped
    write_reg(REG_SPEED_LIMIT, 24'd0);
    write_reg(CfgIdxW'(REG_TURN_LIMIT + 1), 24'hFFFFFF);
    @(negedge clk_i);
    demand_queue.push_back(demand(5, 0));
    demand_queue.push_back(demand(0, 0));
    drain();

    // separate mode: change detection, counter, limits hit exactly
    write_reg(REG_WHEEL_MODE, 24'd1);
    write_reg(REG_SPEED_LIMIT, 24'd500);
    write_reg(REG_TURN_LIMIT, 24'd100);
    @(negedge clk_i);
    demand_queue.push_back(demand(500, 0));
    demand_queue.push_back(demand(500, 0));
    demand_queue.push_back(demand(500, 0));
    demand_queue.push_back(demand(501, -100));
    demand_queue.push_back(demand(501, -100));
    demand_queue.push_back(demand(-600, -101));
    demand_queue.push_back(demand(-32768, -32768));
    demand_queue.push_back(demand(0, -32768));
    drain();

    for (int p = 0; p < NumSettings; p++) begin
      mode = p[0];
      if ($urandom_range(1)) begin
        write_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, REG_TURN_LIMIT + 1)),
                  CfgDataW'($urandom()));
      end
      write_reg(REG_WHEEL_MODE, {23'($urandom()), mode});
      write_reg(REG_TURN_GAIN, 24'(pick(0, 24'hFFFFFF, 65536)));
      write_reg(REG_WHEEL_DIVISOR, {16'($urandom()), 8'(pick(0, 255, 20))});
      write_reg(REG_SPEED_LIMIT, {9'($urandom()), 15'(pick(0, 32767, 500))});
      write_reg(REG_TURN_LIMIT, {9'($urandom()), 15'(pick(0, 32767, 100))});
      @(negedge clk_i);
      if (p < NumSettings / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 46;
      end else if (p < 2 * NumSettings / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (ItemsPerSetting) begin
        spd_v = next_value(spd_v);
        trn_v = next_value(trn_v);
        demand_queue.push_back({trn_v, spd_v});
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Ran %0d demands over %0d register settings in both modes.",
             n_demands, NumSettings + 4);
    $display("Commands seen: %0d wheel, %0d translational, %0d rotational, %0d limited.",
             n_wheel, n_trans, n_rot, n_limited);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // about eight times the slowest expected run
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
